/* rtl/edb_pkg.sv */
// Package for the error diffusion binarizer: register map, field widths,
// reset values and arithmetic constants. No dependencies.
package edb_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned HEIGHT_LIMIT  = 4096;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // Byte addresses of the configuration registers.
  localparam logic [CFG_AW-1:0] ADDR_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_IMAGE_HEIGHT = 3'd4;

  localparam int unsigned WIDTH_REG_W  = 12;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned ROW_W        = 12;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned ERR_W   = 8;  // stored share for the next row
  localparam int unsigned RIGHT_W = 7;  // 3e/8
  localparam int unsigned DIAG_W  = 6;  // e/4

  localparam logic [GRAY_W-1:0] WHITE_THRESH = 8'd127;
  localparam logic [GRAY_W-1:0] GRAY_MAX     = 8'd255;

  typedef struct packed {
    logic             restart;
    logic [ROW_W-1:0] row_last;
  } cfg_ctl_t;

endpackage

/* rtl/edb_line_mem.sv */
// Line memory that holds the error shares pushed onto the next row.
// One write port and one read port with registered read data; uses edb_pkg.
module edb_line_mem #(
  parameter int unsigned DEPTH = edb_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr,
  output logic signed [edb_pkg::ERR_W-1:0]     rd_data,
  input  logic                                 wr_en,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr,
  input  logic signed [edb_pkg::ERR_W-1:0]     wr_data
);

  logic signed [edb_pkg::ERR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/edb_cfg_regs.sv */
// Configuration registers (frame width and height) behind an APB-style port,
// with the clamped last column and last row derived from them; uses edb_pkg.
module edb_cfg_regs #(
  parameter int unsigned MAX_WIDTH = edb_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [edb_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [edb_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [edb_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready,
  output logic [$clog2(MAX_WIDTH)-1:0]   col_last,
  output edb_pkg::cfg_ctl_t              ctl
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  logic [edb_pkg::WIDTH_REG_W-1:0]  width_r, width_nxt;
  logic [edb_pkg::HEIGHT_REG_W-1:0] height_r, height_nxt;
  logic                             wr_hit;
  logic                             wr_width;
  logic                             wr_height;

  assign cfg_pready = 1'b1;
  assign wr_hit     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign wr_width   = wr_hit && (cfg_paddr == edb_pkg::ADDR_IMAGE_WIDTH);
  assign wr_height  = wr_hit && (cfg_paddr == edb_pkg::ADDR_IMAGE_HEIGHT);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_width) begin
      width_nxt = cfg_pwdata[edb_pkg::WIDTH_REG_W-1:0];
    end
    if (wr_height) begin
      height_nxt = cfg_pwdata[edb_pkg::HEIGHT_REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= edb_pkg::WIDTH_RESET;
      height_r <= edb_pkg::HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr)
      edb_pkg::ADDR_IMAGE_WIDTH:  cfg_prdata = edb_pkg::CFG_DW'(width_r);
      edb_pkg::ADDR_IMAGE_HEIGHT: cfg_prdata = edb_pkg::CFG_DW'(height_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // A width or height of zero acts as one; larger values clamp to the limit.
  always_comb begin
    if (width_r == '0) begin
      col_last = '0;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(width_r - 12'd1);
    end
  end

  always_comb begin
    if (height_r == '0) begin
      ctl.row_last = '0;
    end else if (32'(height_r) > 32'(edb_pkg::HEIGHT_LIMIT)) begin
      ctl.row_last = edb_pkg::ROW_W'(edb_pkg::HEIGHT_LIMIT - 1);
    end else begin
      ctl.row_last = edb_pkg::ROW_W'(height_r - 13'd1);
    end
    // Any register write starts a new frame.
    ctl.restart = wr_width | wr_height;
  end

endmodule

/* rtl/edb_quantizer.sv */
// Per-pixel arithmetic: adds the incoming shares, saturates, thresholds and
// splits the error into the right, below and diagonal shares; uses edb_pkg.
module edb_quantizer (
  input  logic [edb_pkg::GRAY_W-1:0]          gray,
  input  logic signed [edb_pkg::RIGHT_W-1:0]  right_share,
  input  logic signed [edb_pkg::ERR_W-1:0]    below_share,
  input  logic signed [edb_pkg::DIAG_W-1:0]   diag_share,
  input  logic                                first_col,
  input  logic                                first_row,
  input  logic                                last_col,
  output logic                                white,
  output logic signed [edb_pkg::ERR_W-1:0]    store_share,
  output logic signed [edb_pkg::RIGHT_W-1:0]  right_nxt,
  output logic signed [edb_pkg::DIAG_W-1:0]   diag_nxt
);

  logic signed [9:0]                  right_x;
  logic signed [9:0]                  below_x;
  logic signed [9:0]                  sum;
  logic [edb_pkg::GRAY_W-1:0]         sat;
  logic signed [8:0]                  err;
  logic signed [10:0]                 err3;
  logic signed [10:0]                 adj3;
  logic signed [8:0]                  adj2;
  logic signed [edb_pkg::RIGHT_W-1:0] down;
  logic signed [edb_pkg::DIAG_W-1:0]  quarter;
  logic signed [edb_pkg::ERR_W-1:0]   diag_x;

  always_comb begin
    right_x = first_col ? 10'sd0 : {{3{right_share[6]}}, right_share};
    below_x = first_row ? 10'sd0 : {{2{below_share[7]}}, below_share};
    sum     = $signed({2'b00, gray}) + right_x + below_x;

    if (sum[9]) begin
      sat = '0;
    end else if (sum[8]) begin
      sat = edb_pkg::GRAY_MAX;
    end else begin
      sat = sum[7:0];
    end

    white = (sat > edb_pkg::WHITE_THRESH);
    err   = white ? ($signed({1'b0, sat}) - 9'sd255) : $signed({1'b0, sat});

    // Division toward zero: bias negative values by divisor minus one.
    err3    = {{2{err[8]}}, err} + {err[8], err, 1'b0};
    adj3    = err3 + {8'b0, {3{err3[10]}}};
    down    = adj3[9:3];
    adj2    = err + {7'b0, {2{err[8]}}};
    quarter = adj2[7:2];

    diag_x      = first_col ? 8'sd0 : {{2{diag_share[5]}}, diag_share};
    store_share = {down[6], down} + diag_x;
    right_nxt   = last_col ? 7'sd0 : down;
    diag_nxt    = last_col ? 6'sd0 : quarter;
  end

endmodule

/* rtl/error_diffusion_binarizer_unit.sv */
// Error diffusion binarizer: turns a raster stream of 8-bit gray pixels into
// one black/white word per pixel, diffusing each pixel's error 3/8 right,
// 3/8 down and 1/4 down-right with saturation to 0..255. The block takes one
// pixel per clock while the result channel does not stall. The line memory
// read completes at the accepting edge into stage one, and the arithmetic
// runs from stage one into an output register in front of the result
// channel. The line memory holds one
// share per column and is never swept: the first row of each frame ignores
// its contents, so it needs no clearing pass after reset or a register write.
// A register write restarts the frame. Uses edb_pkg, edb_cfg_regs,
// edb_line_mem and edb_quantizer.
module error_diffusion_binarizer_unit #(
  parameter int unsigned MAX_WIDTH = edb_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [7:0] pixel_gray
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  // out_tdata: [0] pixel_white, [7:1] zero
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,
  output logic                           out_tlast,
  // out_tuser: [0] frame_end
  output logic                           out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [edb_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [edb_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [edb_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  edb_pkg::cfg_ctl_t                 ctl;
  logic [COL_W-1:0]                  col_last;

  logic [COL_W-1:0]                  col_r, col_nxt;
  logic [edb_pkg::ROW_W-1:0]         row_r, row_nxt;
  logic                              in_fire;
  logic                              in_last_col;
  logic                              in_last_row;

  logic                              s1_valid_r, s1_valid_nxt;
  logic [edb_pkg::GRAY_W-1:0]        s1_gray_r;
  logic [COL_W-1:0]                  s1_col_r;
  logic                              s1_first_col_r;
  logic                              s1_first_row_r;
  logic                              s1_last_col_r;
  logic                              s1_last_row_r;
  logic                              s1_go;

  logic signed [edb_pkg::ERR_W-1:0]   mem_rd_data;
  logic                               fwd_hit_r;
  logic signed [edb_pkg::ERR_W-1:0]   fwd_data_r;
  logic signed [edb_pkg::ERR_W-1:0]   below;

  logic signed [edb_pkg::RIGHT_W-1:0] right_r, right_nxt;
  logic signed [edb_pkg::DIAG_W-1:0]  diag_r, diag_nxt;
  logic                               q_white;
  logic signed [edb_pkg::ERR_W-1:0]   q_store;
  logic signed [edb_pkg::RIGHT_W-1:0] q_right;
  logic signed [edb_pkg::DIAG_W-1:0]  q_diag;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_white_r;
  logic                               out_last_r;
  logic                               out_frame_r;

  edb_cfg_regs #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .col_last    (col_last),
    .ctl         (ctl)
  );

  // Pipeline control: stage one moves on when the output register is free.
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  assign in_last_col = (col_r == col_last);
  assign in_last_row = (row_r == ctl.row_last);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (ctl.restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (in_last_col) begin
        col_nxt = '0;
        row_nxt = in_last_row ? '0 : row_r + edb_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_gray_r      <= in_tdata;
      s1_col_r       <= col_r;
      s1_first_col_r <= (col_r == '0);
      s1_first_row_r <= (row_r == '0);
      s1_last_col_r  <= in_last_col;
      s1_last_row_r  <= in_last_row;
      // The word ahead may be writing the column being read this very edge.
      fwd_hit_r      <= s1_go && (s1_col_r == col_r);
      fwd_data_r     <= q_store;
    end
  end

  edb_line_mem #(.DEPTH(MAX_WIDTH)) u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (mem_rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (q_store)
  );

  assign below = fwd_hit_r ? fwd_data_r : mem_rd_data;

  edb_quantizer u_quant (
    .gray        (s1_gray_r),
    .right_share (right_r),
    .below_share (below),
    .diag_share  (diag_r),
    .first_col   (s1_first_col_r),
    .first_row   (s1_first_row_r),
    .last_col    (s1_last_col_r),
    .white       (q_white),
    .store_share (q_store),
    .right_nxt   (q_right),
    .diag_nxt    (q_diag)
  );

  always_comb begin
    right_nxt = right_r;
    diag_nxt  = diag_r;
    if (ctl.restart) begin
      right_nxt = '0;
      diag_nxt  = '0;
    end else if (s1_go) begin
      right_nxt = q_right;
      diag_nxt  = q_diag;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_r     <= '0;
      diag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      right_r     <= right_nxt;
      diag_r      <= diag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_white_r <= q_white;
      out_last_r  <= s1_last_col_r;
      out_frame_r <= s1_last_col_r & s1_last_row_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_white_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_frame_r;

`ifndef SYNTH
  a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_r |-> out_last_r)
    else $error("frame end flagged on a word that does not end its row");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= col_last)
    else $error("column counter ran past the last column");

  a_fwd_single_col: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && fwd_hit_r |-> s1_first_col_r)
    else $error("line memory forwarding used outside a one-column frame");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_col_r))
    else $error("stalled pixel left stage one");

  a_out_loaded_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a pixel in stage one");
`endif

endmodule

/* dv/error_diffusion_binarizer_unit_test.sv */
// Self-checking testbench for error_diffusion_binarizer_unit: drives gray pixel
// words and register writes, predicts each black/white word and compares.
// Depends on edb_pkg and the error_diffusion_binarizer_unit RTL.
module error_diffusion_binarizer_unit_test;
  import edb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PIXELS = 500;

  typedef struct packed {
    logic white;
    logic row_end;
    logic frame_end;
  } bw_word_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [7:0]              in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [7:0]              out_tdata;
  logic                    out_tlast;
  logic                    out_tuser;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CFG_AW-1:0]       cfg_paddr;
  logic [CFG_DW-1:0]       cfg_pwdata;
  logic [CFG_DW-1:0]       cfg_prdata;
  logic                    cfg_pready;

  // Predictor state: register copies, diffusion shares and frame position.
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int                      next_row_share [MAX_WIDTH_DEF];
  int                      right_share;
  int                      diag_share;
  int                      col_pos;
  int                      row_pos;

  bw_word_t                bw_pending [$];
  bw_word_t                bw_due;
  int                      mismatch_count;
  int                      pixels_sent;
  int                      words_checked;
  int                      settings_used;
  int                      cycle_count;
  bit                      no_gaps;

  error_diffusion_binarizer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
               bw_pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (word %0d)", what, got, want,
             words_checked);
    mismatch_count++;
  endtask

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == 0) return 1;
    return (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg);
  endfunction

  task automatic restart_frame();
    foreach (next_row_share[i]) next_row_share[i] = 0;
    right_share = 0;
    diag_share  = 0;
    col_pos     = 0;
    row_pos     = 0;
  endtask

  // Works out the word for one accepted pixel and advances the diffusion state.
  task automatic predict_pixel(input logic [7:0] gray);
    int       w;
    int       h;
    int       sum;
    int       err;
    int       down;
    bit       last_col;
    bit       last_row;
    bw_word_t word;
    w = eff_width();
    h = eff_height();
    last_col = (col_pos == w - 1);
    last_row = (row_pos == h - 1);
    sum = int'(gray);
    if (col_pos != 0) sum += right_share;
    if (row_pos != 0) sum += next_row_share[col_pos];
    if (sum < 0) sum = 0;
    if (sum > int'(GRAY_MAX)) sum = int'(GRAY_MAX);
    word.white = (sum > int'(WHITE_THRESH));
    err = word.white ? sum - int'(GRAY_MAX) : sum;
    down = (3 * err) / 8;
    next_row_share[col_pos] = down + ((col_pos != 0) ? diag_share : 0);
    right_share = last_col ? 0 : down;
    diag_share  = last_col ? 0 : err / 4;
    word.row_end   = last_col;
    word.frame_end = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    bw_pending.push_back(word);
  endtask

  // Every accepted word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (bw_pending.size() == 0) begin
        report_mismatch("word with nothing pending", int'(out_tdata), -1);
      end else begin
        bw_due = bw_pending.pop_front();
        if (out_tdata !== {7'd0, bw_due.white})
          report_mismatch("pixel_white", int'(out_tdata), int'(bw_due.white));
        if (out_tlast !== bw_due.row_end)
          report_mismatch("row_end", int'(out_tlast), int'(bw_due.row_end));
        if (out_tuser !== bw_due.frame_end)
          report_mismatch("frame_end", int'(out_tuser), int'(bw_due.frame_end));
      end
      words_checked++;
    end
  end

  // Result side: random stall before each word, none while no_gaps is set.
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(input logic [7:0] gray);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = gray;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_pixel(gray);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (bw_pending.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (addr == ADDR_IMAGE_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
    else if (addr == ADDR_IMAGE_HEIGHT) height_reg = data[HEIGHT_REG_W-1:0];
    restart_frame();
    settings_used++;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic cfg_read(input logic [CFG_AW-1:0] addr, output logic [CFG_DW-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = addr;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic check_registers();
    logic [CFG_DW-1:0] value;
    cfg_read(ADDR_IMAGE_WIDTH, value);
    if (value !== CFG_DW'(width_reg))
      report_mismatch("image_width readback", int'(value), int'(width_reg));
    cfg_read(ADDR_IMAGE_HEIGHT, value);
    if (value !== CFG_DW'(height_reg))
      report_mismatch("image_height readback", int'(value), int'(height_reg));
  endtask

  task automatic set_frame(input int width, input int height);
    wait_drained();
    cfg_write(ADDR_IMAGE_WIDTH, CFG_DW'(width));
    cfg_write(ADDR_IMAGE_HEIGHT, CFG_DW'(height));
  endtask

  // Mix of saturating extremes, threshold neighbors and plain random levels.
  function automatic logic [7:0] draw_gray();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return GRAY_MAX;
      2:       return $urandom_range(0, 1) ? WHITE_THRESH : WHITE_THRESH + 8'd1;
      3:       return 8'($urandom_range(0, 20));
      4:       return 8'($urandom_range(235, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_reset_values();
    check_registers();
    // Reset geometry is 640 wide, so these stay within the first row.
    for (int i = 0; i < 8; i++) send_pixel(8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    logic [7:0] frame_px [6] = '{8'd100, 8'd255, 8'd155, 8'd0, 8'd255, 8'd0};
    set_frame(3, 2);
    check_registers();
    foreach (frame_px[i]) send_pixel(frame_px[i]);
    // Roll into the next frame, then pause until the block is empty.
    send_pixel(8'd128);
    send_pixel(8'd127);
    wait_drained();
    // A register write in mid-frame starts a new frame.
    cfg_write(ADDR_IMAGE_HEIGHT, CFG_DW'(2));
    for (int i = 0; i < 3; i++) send_pixel(i[0] ? 8'd1 : 8'd254);
    // Zero sizes act as one pixel: every word ends a row and a frame.
    set_frame(0, 0);
    check_registers();
    for (int i = 0; i < 3; i++) send_pixel(draw_gray());
  endtask

  task automatic test_large_frames();
    // Oversized width clamps to the line memory depth; the start of one row.
    set_frame((1 << WIDTH_REG_W) - 1, 1);
    check_registers();
    no_gaps = 1'b1;
    for (int i = 0; i < 30; i++) send_pixel(draw_gray());
    no_gaps = 1'b0;
    for (int i = 30; i < 60; i++) send_pixel(draw_gray());
    // Oversized height clamps to the row limit; a one-pixel-wide column.
    set_frame(1, (1 << HEIGHT_REG_W) - 1);
    check_registers();
    for (int i = 0; i < 40; i++) send_pixel(draw_gray());
    set_frame(MAX_WIDTH_DEF, HEIGHT_LIMIT);
    for (int i = 0; i < 30; i++) send_pixel(draw_gray());
  endtask

  task automatic test_random_frames();
    int target;
    int width;
    int height;
    int count;
    int pause_at;
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      case ($urandom_range(0, 9))
        0:       width = 0;
        1:       width = $urandom_range(17, 80);
        default: width = $urandom_range(1, 16);
      endcase
      height = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      wait_drained();
      case ($urandom_range(0, 3))
        0:       cfg_write(ADDR_IMAGE_WIDTH, CFG_DW'(width));
        1:       cfg_write(ADDR_IMAGE_HEIGHT, CFG_DW'(height));
        default: begin
          cfg_write(ADDR_IMAGE_WIDTH, CFG_DW'(width));
          cfg_write(ADDR_IMAGE_HEIGHT, CFG_DW'(height));
        end
      endcase
      if ($urandom_range(0, 3) == 0) check_registers();
      no_gaps = ($urandom_range(0, 3) == 0);
      count = eff_width() * eff_height() * $urandom_range(1, 2) +
              $urandom_range(0, eff_width());
      if (count > 200) count = 200;
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, count - 1) : -1;
      for (int i = 0; i < count; i++) begin
        if (i == pause_at) wait_drained();
        send_pixel(draw_gray());
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    no_gaps        = 1'b0;
    mismatch_count = 0;
    pixels_sent    = 0;
    words_checked  = 0;
    settings_used  = 0;
    cycle_count    = 0;
    width_reg      = WIDTH_RESET;
    height_reg     = HEIGHT_RESET;
    restart_frame();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_values();
    test_directed();
    test_large_frames();
    test_random_frames();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d pixels and checked %0d words across %0d register writes,",
             pixels_sent, words_checked, settings_used);
    $display("including zero and oversized frame sizes and many random small frames.");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/edb_pkg.sv
rtl/edb_line_mem.sv
rtl/edb_cfg_regs.sv
rtl/edb_quantizer.sv
rtl/error_diffusion_binarizer_unit.sv
dv/error_diffusion_binarizer_unit_test.sv
